FILE: rtl/core/sem_pkg.sv
// shared types, constants and codes of the rgb sobel edge magnitude block
`timescale 1ns / 1ps

package sem_pkg;

   // geometry and field widths
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_REG_W  = 13;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int WIDTH_RESET   = 1024;
   localparam int HEIGHT_RESET  = 1;
   localparam int ROW_W         = 14;
   localparam int CH_W          = 8;
   localparam int NUM_CH        = 3;
   localparam int PIX_W         = NUM_CH * CH_W;
   localparam int WIN_SIZE      = 9;
   localparam int GRAD_W        = 11;
   localparam int MAG_W         = 21;
   localparam int ROOT_IDX_W    = $clog2(CH_W);

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // item kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // input transaction payload
   typedef struct packed {
      logic            req_type;
      logic [CH_W-1:0] red_in;
      logic [CH_W-1:0] green_in;
      logic [CH_W-1:0] blue_in;
   } sem_req_type;

   // result transaction payload
   typedef struct packed {
      logic [CH_W-1:0] red_edge;
      logic [CH_W-1:0] green_edge;
      logic [CH_W-1:0] blue_edge;
      logic            frame_end;
   } sem_rsp_type;

   // which window rows and columns lie inside the frame (middle ones always do)
   typedef struct packed {
      logic row_top;
      logic row_bot;
      logic col_left;
      logic col_right;
   } sem_border_type;

   // per-stage enables for the channel lanes
   typedef struct packed {
      logic                  grad_en;
      logic                  sq_en;
      logic                  root_en;
      logic [ROOT_IDX_W-1:0] root_idx;
   } sem_lane_ctrl_type;

endpackage

FILE: rtl/core/sem_line_buf.sv
// two line stores of packed rgb pixels with registered read ports
`timescale 1ns / 1ps

module sem_line_buf #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic                     wr_en,
   input  logic                     bank,
   input  logic [COL_W-1:0]         col,
   input  logic [sem_pkg::PIX_W-1:0] wdata,
   output logic [sem_pkg::PIX_W-1:0] top_q,
   output logic [sem_pkg::PIX_W-1:0] mid_q
);
   import sem_pkg::*;

   logic [PIX_W-1:0] mem [2][MAX_WIDTH];
   logic [PIX_W-1:0] top_ff;
   logic [PIX_W-1:0] mid_ff;

   // write the current row's bank, read both banks before the write lands
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[bank][col] <= wdata;
      end
      if (rd_en) begin
         top_ff <= mem[bank][col];
         mid_ff <= mem[~bank][col];
      end
   end

   assign top_q = top_ff;
   assign mid_q = mid_ff;

endmodule

FILE: rtl/core/sem_lane.sv
// one color channel lane: sobel gradients, squared magnitude, bitwise rounded root
`timescale 1ns / 1ps

module sem_lane (
   input  logic                        clock,
   input  sem_pkg::sem_lane_ctrl_type  ctrl,
   input  sem_pkg::sem_border_type     border,
   input  logic [sem_pkg::CH_W-1:0]    pix [sem_pkg::WIN_SIZE],
   output logic [sem_pkg::CH_W-1:0]    edge_mag
);
   import sem_pkg::*;

   logic [GRAD_W:0]          v [WIN_SIZE];
   logic [GRAD_W:0]          gx_pos, gx_neg, gy_pos, gy_neg;
   logic [GRAD_W:0]          gx_full, gy_full;
   logic signed [GRAD_W-1:0] gx_ff, gx_in;
   logic signed [GRAD_W-1:0] gy_ff, gy_in;
   logic signed [2*GRAD_W-1:0] sq_x, sq_y, sq_sum;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic [CH_W-1:0]          k_ff, k_in;
   logic [CH_W-1:0]          cand;
   logic [2*CH_W-1:0]        prod;
   logic [2:0]               row_ok;
   logic [2:0]               col_ok;

   // zero the taps that fall outside the frame
   always_comb begin
      row_ok = {border.row_bot, 1'b1, border.row_top};
      col_ok = {border.col_right, 1'b1, border.col_left};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            v[r*3+c] = (row_ok[r] && col_ok[c]) ? (GRAD_W+1)'(pix[r*3+c]) : '0;
         end
      end
   end

   // gradients, wrapped arithmetic fits the signed result exactly
   always_comb begin
      gx_pos  = v[2] + (v[5] << 1) + v[8];
      gx_neg  = v[0] + (v[3] << 1) + v[6];
      gy_pos  = v[6] + (v[7] << 1) + v[8];
      gy_neg  = v[0] + (v[1] << 1) + v[2];
      gx_full = gx_pos - gx_neg;
      gy_full = gy_pos - gy_neg;
      gx_in   = ctrl.grad_en ? signed'(gx_full[GRAD_W-1:0]) : gx_ff;
      gy_in   = ctrl.grad_en ? signed'(gy_full[GRAD_W-1:0]) : gy_ff;
   end

   // squared magnitude
   always_comb begin
      sq_x   = gx_ff * gx_ff;
      sq_y   = gy_ff * gy_ff;
      sq_sum = sq_x + sq_y;
      mag_in = ctrl.sq_en ? sq_sum[MAG_W-1:0] : mag_ff;
   end

   // one root bit per cycle: keep the largest k with k(k-1) below the magnitude
   always_comb begin
      cand = k_ff | (CH_W'(1) << ctrl.root_idx);
      prod = (2*CH_W)'(cand) * (2*CH_W)'(cand - 1'b1);
      k_in = k_ff;
      if (ctrl.sq_en) begin
         k_in = '0;
      end else if (ctrl.root_en && (MAG_W'(prod) < mag_ff)) begin
         k_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      gx_ff  <= gx_in;
      gy_ff  <= gy_in;
      mag_ff <= mag_in;
      k_ff   <= k_in;
   end

   assign edge_mag = k_ff;

endmodule

FILE: rtl/core/sobel_edge_magnitude_rgb.sv
// top level of the rgb sobel edge magnitude block: positions, window, lanes, result merge
`timescale 1ns / 1ps

// Usage:
// Pixels enter on the req_ channel in raster order (valid/ready). Each accepted
// transaction shifts the 3x3 window; the result for a pixel leaves on the rsp_
// channel frame_width+1 transactions later, so the host sends frame_width+1 flush
// transactions after each frame. frame_end marks the frame's last pixel.
// csr_we/csr_index/csr_wdata set frame width and height; a write restarts the frame and
// clears the window. The user makes a write only while the block is idle; the block
// itself does not enforce this. Timing: a transaction that yields a result passes the
// line store read, window shift, gradient, square and eight-step rounded square root
// states of each channel lane; rsp_valid shows and req_ready returns in the same cycle,
// and no new pixel is taken before then. A transaction with no result passes only the
// line store read and window shift. The result register is separate, so a new pixel is
// accepted while a result waits; if the receiver stalls, a finished result holds in the
// last stage and further pixels wait until the result register frees up.
// Reset: synchronous; width 1024 (capped to MAX_WIDTH), height 1, window zero,
// position zero, no result pending. The line stores need no clearing.

module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sem_pkg::sem_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sem_pkg::sem_rsp_type            rsp_data,
   input  logic                            csr_we,
   input  logic [sem_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sem_pkg::*;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WID_W      = $clog2(MAX_WIDTH + 1);
   localparam int WIDTH_INIT = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

   localparam logic [ROW_W-1:0] ROW_ONE   = ROW_W'(1);
   localparam logic [ROW_W-1:0] ROW_TWO   = ROW_W'(2);
   localparam logic [ROW_W-1:0] ROW_THREE = ROW_W'(3);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_WIN  = 3'd1;
   localparam logic [2:0] ST_GRAD = 3'd2;
   localparam logic [2:0] ST_SQ   = 3'd3;
   localparam logic [2:0] ST_ROOT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [WID_W-1:0]        width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [PIX_W-1:0]        win_ff [WIN_SIZE];
   logic [PIX_W-1:0]        win_in [WIN_SIZE];
   logic [PIX_W-1:0]        pix_ff, pix_in;
   logic                    top_ok_ff, top_ok_in;
   logic                    mid_ok_ff, mid_ok_in;
   logic                    emit_ff, emit_in;
   logic                    last_ff, last_in;
   sem_border_type          border_ff, border_in;
   logic [ROOT_IDX_W-1:0]   idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sem_rsp_type             rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    cfg_wr;
   logic [31:0]             width_req;
   logic [HEIGHT_REG_W-1:0] height_req;
   logic [COL_W-1:0]        col_eff;
   logic [WID_W-1:0]        col_inc;
   logic [ROW_W-1:0]        h_ext, h_p1;
   logic                    col_pos;
   logic                    top_ok, mid_ok, wr_ok, emit, last;
   sem_border_type          border;
   logic [PIX_W-1:0]        pix_val;
   logic [PIX_W-1:0]        top_q, mid_q;
   logic                    rsp_load;
   sem_lane_ctrl_type       lane_ctrl;
   logic [CH_W-1:0]         lane_pix [NUM_CH][WIN_SIZE];
   logic [CH_W-1:0]         lane_edge [NUM_CH];

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign cfg_wr    = csr_we && ((csr_index == CSR_FRAME_WIDTH) ||
                                 (csr_index == CSR_FRAME_HEIGHT));

   // configuration registers hold the clamped effective sizes
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      width_req  = 32'(csr_wdata[WIDTH_REG_W-1:0]);
      height_req = csr_wdata[HEIGHT_REG_W-1:0];
      if (csr_we && (csr_index == CSR_FRAME_WIDTH)) begin
         if (width_req == 32'd0) begin
            width_in = WID_W'(1);
         end else if (width_req > 32'(MAX_WIDTH)) begin
            width_in = WID_W'(MAX_WIDTH);
         end else begin
            width_in = width_req[WID_W-1:0];
         end
      end
      if (csr_we && (csr_index == CSR_FRAME_HEIGHT)) begin
         if (height_req == '0) begin
            height_in = HEIGHT_REG_W'(1);
         end else if (height_req > HEIGHT_REG_W'(HEIGHT_LIMIT)) begin
            height_in = HEIGHT_REG_W'(HEIGHT_LIMIT);
         end else begin
            height_in = height_req;
         end
      end
   end

   // position decode for the incoming transaction
   always_comb begin
      col_eff = (WID_W'(col_ff) >= width_ff) ? COL_W'(width_ff - 1'b1) : col_ff;
      h_ext   = ROW_W'(height_ff);
      h_p1    = h_ext + 1'b1;
      col_pos = (col_eff != '0);
      top_ok  = (row_ff >= ROW_TWO) && (row_ff <= h_p1);
      mid_ok  = (row_ff >= ROW_ONE) && (row_ff <= h_ext);
      wr_ok   = (row_ff < h_ext);
      emit    = col_pos ? mid_ok : top_ok;
      last    = !col_pos && (row_ff == h_p1);
      border.row_top   = col_pos ? (row_ff >= ROW_TWO) : (row_ff >= ROW_THREE);
      border.row_bot   = col_pos ? (row_ff < h_ext) : (row_ff <= h_ext);
      border.col_left  = col_pos ? (col_eff >= COL_W'(2)) : (width_ff >= WID_W'(2));
      border.col_right = col_pos;
      col_inc = WID_W'(col_eff) + 1'b1;
      pix_val = (req_data.req_type == REQ_PIXEL) ?
                {req_data.red_in, req_data.green_in, req_data.blue_in} : '0;
   end

   // position advance, restart on configuration or after the frame's last result
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (emit && last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= width_ff) begin
            col_in = '0;
            if (row_ff <= h_p1) begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   // line stores
   sem_line_buf #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_line_buf (
      .clock (clock),
      .rd_en (accept),
      .wr_en (accept && wr_ok),
      .bank  (row_ff[0]),
      .col   (col_eff),
      .wdata (pix_val),
      .top_q (top_q),
      .mid_q (mid_q)
   );

   // per-transaction flags captured at acceptance
   always_comb begin
      pix_in    = accept ? pix_val : pix_ff;
      top_ok_in = accept ? top_ok  : top_ok_ff;
      mid_ok_in = accept ? mid_ok  : mid_ok_ff;
      emit_in   = accept ? emit    : emit_ff;
      last_in   = accept ? last    : last_ff;
      border_in = accept ? border  : border_ff;
   end

   // window shift once the line store data is back, cleared on a configuration write
   always_comb begin
      for (int e = 0; e < WIN_SIZE; e++) begin
         win_in[e] = win_ff[e];
      end
      if (cfg_wr) begin
         for (int e = 0; e < WIN_SIZE; e++) begin
            win_in[e] = '0;
         end
      end else if (state_ff == ST_WIN) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r*3]   = win_ff[r*3+1];
            win_in[r*3+1] = win_ff[r*3+2];
         end
         win_in[2] = top_ok_ff ? top_q : '0;
         win_in[5] = mid_ok_ff ? mid_q : '0;
         win_in[8] = pix_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            state_in = emit_ff ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: begin
            state_in = ST_SQ;
         end
         ST_SQ: begin
            state_in = ST_ROOT;
            idx_in   = ROOT_IDX_W'(CH_W - 1);
         end
         ST_ROOT: begin
            if (idx_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // lane controls and channel slices of the window
   always_comb begin
      lane_ctrl.grad_en  = (state_ff == ST_GRAD);
      lane_ctrl.sq_en    = (state_ff == ST_SQ);
      lane_ctrl.root_en  = (state_ff == ST_ROOT);
      lane_ctrl.root_idx = idx_ff;
      for (int g = 0; g < NUM_CH; g++) begin
         for (int e = 0; e < WIN_SIZE; e++) begin
            lane_pix[g][e] = win_ff[e][PIX_W-1-CH_W*g -: CH_W];
         end
      end
   end

   // one lane per color channel
   for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
      sem_lane u_lane (
         .clock    (clock),
         .ctrl     (lane_ctrl),
         .border   (border_ff),
         .pix      (lane_pix[g]),
         .edge_mag (lane_edge[g])
      );
   end

   // merge lane results into the output register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in.red_edge   = lane_edge[0];
         rsp_data_in.green_edge = lane_edge[1];
         rsp_data_in.blue_edge  = lane_edge[2];
         rsp_data_in.frame_end  = last_ff;
         rsp_valid_in           = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WID_W'(WIDTH_INIT);
         height_ff    <= HEIGHT_REG_W'(HEIGHT_RESET);
         col_ff       <= '0;
         row_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int e = 0; e < WIN_SIZE; e++) begin
            win_ff[e] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int e = 0; e < WIN_SIZE; e++) begin
            win_ff[e] <= win_in[e];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      top_ok_ff   <= top_ok_in;
      mid_ok_ff   <= mid_ok_in;
      emit_ff     <= emit_in;
      last_ff     <= last_in;
      border_ff   <= border_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the rgb sobel edge magnitude block: random frames against a predictor
`timescale 1ns / 1ps

module tb_top;
   import sem_pkg::*;

   localparam int MAX_W         = MAX_WIDTH_DEF;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 2000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   sem_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   sem_rsp_type           rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // stimulus and scoreboard bookkeeping
   sem_req_type stream_q[$];
   sem_rsp_type edges_due[$];
   int          items_sent = 0;
   int          items_taken = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          gap_max = 9;
   int          rsp_max = 9;
   int          req_gap = 0;
   int          rsp_stall = 0;
   logic        req_accepted = 1'b0;
   logic        rsp_accepted = 1'b0;
   logic [10:0] raw_width = 11'(WIDTH_RESET);
   logic [12:0] raw_height = 13'(HEIGHT_RESET);

   // predictor state
   logic [PIX_W-1:0] line_mem [0:2*MAX_W-1];
   logic [PIX_W-1:0] win [0:WIN_SIZE-1];
   int               col_pos;
   int               row_pos;
   logic [10:0]      width_reg;
   logic [12:0]      height_reg;

   sobel_edge_magnitude_rgb dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock generation
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // width and height as the block uses them
   function automatic int eff_cols(input logic [10:0] raw);
      int w;
      w = raw;
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int eff_rows(input logic [12:0] raw);
      int h;
      h = raw;
      if (h == 0) h = 1;
      if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
      return h;
   endfunction

   // position back to the frame start, window emptied
   task automatic restart_frame();
      for (int i = 0; i < WIN_SIZE; i++) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
   endtask

   // rounded gradient magnitude of one channel around window center (rc, cc)
   function automatic logic [7:0] edge_mag(input int sh, input int rc, input int cc,
                                           input int w, input int h);
      int gx, gy, v, n, k;
      gx = 0;
      gy = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            // neighbours outside the frame count as zero
            if (rc - 1 + i >= 0 && rc - 1 + i < h && cc - 1 + j >= 0 && cc - 1 + j < w) begin
               v = (win[i*3+j] >> sh) & 24'hFF;
               // gx kernel: column sign, doubled on the middle row; gy the transpose
               gx += v * (j - 1) * ((i == 1) ? 2 : 1);
               gy += v * (i - 1) * ((j == 1) ? 2 : 1);
            end
         end
      end
      n = gx * gx + gy * gy;
      k = 0;
      while (k < 255 && k * (k + 1) < n) k++;
      return k[7:0];
   endfunction

   // advance the predictor by one accepted transaction
   task automatic predict_edges(input sem_req_type item);
      int          w, h, ri, ci, slot_new, slot_old, rc, cc;
      logic [23:0] pix, top, mid;
      sem_rsp_type res;
      w = eff_cols(width_reg);
      h = eff_rows(height_reg);
      ri = row_pos;
      ci = col_pos;
      pix = '0;
      top = '0;
      mid = '0;
      if (ci >= w) ci = w - 1;
      slot_new = (ri % 2) * MAX_W + ci;
      slot_old = ((ri + 1) % 2) * MAX_W + ci;

      // line stores are read and written only for rows inside the frame
      if (ri >= 2 && ri - 2 < h) top = line_mem[slot_new];
      if (ri >= 1 && ri - 1 < h) mid = line_mem[slot_old];
      if (ri < h) begin
         if (item.req_type == REQ_PIXEL) pix = {item.red_in, item.green_in, item.blue_in};
         line_mem[slot_new] = pix;
      end

      // window shift
      for (int i = 0; i < 3; i++) begin
         win[i*3]   = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = pix;

      // center of the window lags the input by one row and one column; at column zero it is the last column two rows up
      if (ci >= 1) begin
         rc = ri - 1;
         cc = ci - 1;
      end else begin
         rc = ri - 2;
         cc = w - 1;
      end

      if (rc >= 0 && rc < h) begin
         res.red_edge   = edge_mag(16, rc, cc, w, h);
         res.green_edge = edge_mag(8, rc, cc, w, h);
         res.blue_edge  = edge_mag(0, rc, cc, w, h);
         res.frame_end  = (rc == h - 1) && (cc == w - 1);
         edges_due.push_back(res);
      end

      if (rc >= 0 && rc < h && rc == h - 1 && cc == w - 1) begin
         // frame wrap
         row_pos = 0;
         col_pos = 0;
      end else begin
         ci++;
         if (ci >= w) begin
            ci = 0;
            if (ri <= h + 1) ri++;
         end
         col_pos = ci;
         row_pos = ri;
      end
   endtask

   task automatic report_field(input string field, input int want, input int got);
      fail_count++;
      $display("%0t mismatch %s expected %0d actual %0d", $time, field, want, got);
   endtask

   // compare one result transaction with the oldest expectation
   task automatic check_edges(input sem_rsp_type got);
      sem_rsp_type want;
      if (edges_due.size() == 0) begin
         fail_count++;
         $display("%0t unexpected result expected none actual %h", $time, got);
      end else begin
         want = edges_due.pop_front();
         if (got.red_edge !== want.red_edge)
            report_field("red_edge", want.red_edge, got.red_edge);
         if (got.green_edge !== want.green_edge)
            report_field("green_edge", want.green_edge, got.green_edge);
         if (got.blue_edge !== want.blue_edge)
            report_field("blue_edge", want.blue_edge, got.blue_edge);
         if (got.frame_end !== want.frame_end)
            report_field("frame_end", want.frame_end, got.frame_end);
      end
   endtask

   // monitor: sample handshakes and register writes at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
      if (reset) begin
         req_accepted <= 1'b0;
         rsp_accepted <= 1'b0;
         for (int i = 0; i < 2 * MAX_W; i++) line_mem[i] = '0;
         width_reg  = 11'(WIDTH_RESET);
         height_reg = 13'(HEIGHT_RESET);
         restart_frame();
      end else begin
         req_accepted <= req_valid && req_ready;
         rsp_accepted <= rsp_valid && rsp_ready;
         if (csr_we) begin
            if (csr_index == CSR_FRAME_WIDTH) width_reg = csr_wdata[10:0];
            else if (csr_index == CSR_FRAME_HEIGHT) height_reg = csr_wdata[12:0];
            restart_frame();
         end
         if (req_valid && req_ready) begin
            predict_edges(req_data);
            items_taken++;
         end
         if (rsp_valid && rsp_ready) check_edges(rsp_data);
      end
   end

   // driver: present queued transactions at the falling edge, random gap after each
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_accepted)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (stream_q.size() > 0) begin
            req_data  <= stream_q.pop_front();
            req_valid <= 1'b1;
            req_gap = $urandom_range(0, gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall after each result transaction
   always @(negedge clock) begin
      if (rsp_accepted) rsp_stall = $urandom_range(0, rsp_max);
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_item(input logic kind, input logic [23:0] rgb);
      sem_req_type item;
      item.req_type = kind;
      item.red_in   = rgb[23:16];
      item.green_in = rgb[15:8];
      item.blue_in  = rgb[7:0];
      stream_q.push_back(item);
      items_sent++;
   endtask

   // wait until everything sent is taken and answered, then let the pipeline empty
   task automatic settle();
      while (items_taken != items_sent || edges_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_frame(input int raw_w, input int raw_h);
      settle();
      write_csr(CSR_FRAME_WIDTH, raw_w);
      write_csr(CSR_FRAME_HEIGHT, raw_h);
      raw_width  = raw_w[10:0];
      raw_height = raw_h[12:0];
   endtask

   // channel value: narrow spans give unsaturated gradients, sometimes a hard extreme
   function automatic logic [7:0] pick_channel(input int span, input int offset);
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'(offset + $urandom_range(0, span - 1));
      endcase
   endfunction

   // one frame plus its drain positions, optionally cut short
   task automatic send_frame(input bit broken);
      int w, h, total, cut, span, offset;
      logic [23:0] rgb;
      w = eff_cols(raw_width);
      h = eff_rows(raw_height);
      total = w * h + w + 1;
      cut = broken ? $urandom_range(1, total - 1) : total;
      case ($urandom_range(0, 2))
         0:       span = 8;
         1:       span = 48;
         default: span = 256;
      endcase
      offset = $urandom_range(0, 256 - span);
      for (int n = 0; n < cut; n++) begin
         rgb = {pick_channel(span, offset), pick_channel(span, offset),
                pick_channel(span, offset)};
         if (n < w * h) begin
            // an occasional flush inside the frame stands for a black pixel
            if ($urandom_range(0, 19) == 0) push_item(REQ_FLUSH, rgb);
            else push_item(REQ_PIXEL, rgb);
         end else begin
            // a pixel on a drain position has its colour ignored
            if ($urandom_range(0, 4) == 0) push_item(REQ_PIXEL, rgb);
            else push_item(REQ_FLUSH, rgb);
         end
      end
   endtask

   // stimulus sequence
   initial begin
      int rand_start, new_w, new_h, pick, frames;
      bit first_phase;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // a few transactions under the reset geometry, too early for any result
      push_item(REQ_PIXEL, 24'hFFFFFF);
      push_item(REQ_FLUSH, 24'h5A5A5A);
      push_item(REQ_PIXEL, 24'h000000);
      push_item(REQ_PIXEL, 24'h80FF01);

      // 3x2 frame: extremes, flush inside the frame, pixel on a drain position
      set_frame(3, 2);
      push_item(REQ_PIXEL, 24'hFFFFFF);
      push_item(REQ_PIXEL, 24'h000000);
      push_item(REQ_PIXEL, 24'hFF00FF);
      push_item(REQ_FLUSH, 24'hAAAAAA);
      push_item(REQ_PIXEL, 24'h00FF00);
      push_item(REQ_PIXEL, 24'h123456);
      push_item(REQ_FLUSH, 24'hFFFFFF);
      push_item(REQ_PIXEL, 24'hFFFFFF);
      push_item(REQ_FLUSH, 24'h000000);
      push_item(REQ_FLUSH, 24'h0F0F0F);
      // frame wrap straight into the next frame
      send_frame(1'b0);

      // zero width and height act as one
      set_frame(0, 0);
      push_item(REQ_PIXEL, 24'hFFFFFF);
      push_item(REQ_FLUSH, 24'h000000);
      push_item(REQ_PIXEL, 24'h808080);

      // random phases of small frames
      rand_start = items_sent;
      first_phase = 1'b1;
      while (items_sent - rand_start < RANDOM_ITEMS) begin
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         rsp_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         new_w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
         new_h = $urandom_range(0, 6);
         settle();
         pick = $urandom_range(0, 3);
         if (pick != 1) begin
            // upper data bits above the width register are junk
            write_csr(CSR_FRAME_WIDTH, new_w | ($urandom_range(0, 3) << 11));
            raw_width = new_w[10:0];
         end
         if (pick != 0) begin
            write_csr(CSR_FRAME_HEIGHT, new_h);
            raw_height = new_h[12:0];
         end
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            send_frame(f == frames - 1 && $urandom_range(0, 4) == 0);
            // after the first frame of some phases the sender holds off until every result is back
            if (f == 0 && (first_phase || $urandom_range(0, 3) == 0)) settle();
         end
         first_phase = 1'b0;
      end

      settle();
      if (fail_count == 0 && edges_due.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
